/* rtl/packet_field_reader_top_macros.svh */
// Assertion macros for the packet field reader.
// Both sample on i_clk and are disabled while i_rst_n is low.
`ifndef PACKET_FIELD_READER_TOP_MACROS_SVH
`define PACKET_FIELD_READER_TOP_MACROS_SVH

// Same-cycle implication.
`define PFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared sizes, codes and types of the packet field reader.
// ----------------------------------------------------------------------------
package pfr_pkg;

    localparam int BUF_DEPTH = 4096;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);
    localparam int SIZE_W    = $clog2(BUF_DEPTH + 1);
    localparam int OFF_W     = 13;
    localparam int LEN_W     = 15;
    localparam int VAL_W     = 64;
    localparam int CNT_W     = 4;

    localparam logic [LEN_W-1:0] LEN_LIMIT_RESET = 15'h7FFF;
    localparam logic [CNT_W-1:0] VAR_LAST_IDX    = 4'd9;

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    localparam logic [2:0] KIND_BYTE    = 3'd0;
    localparam logic [2:0] KIND_SHORT   = 3'd1;
    localparam logic [2:0] KIND_INT     = 3'd2;
    localparam logic [2:0] KIND_LONG    = 3'd3;
    localparam logic [2:0] KIND_VARLONG = 3'd4;
    localparam logic [2:0] KIND_STRING  = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_LONG = 2'd2;

    typedef struct packed {
        logic             cmd;
        logic [7:0]       data_byte;
        logic             start_packet;
        logic [2:0]       field_kind;
        logic [LEN_W-1:0] string_max;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] field_value;
        logic [OFF_W-1:0]        string_offset;
        logic [1:0]              status;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_BYTE,
        S_CHK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic append;
        logic start_read;
        logic byte_step;
        logic chk;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic kind_bad;
        logic fail;
        logic last;
        logic is_string;
        logic out_free;
    } t_stat;

endpackage

/* rtl/packet_field_reader_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_field_reader_top
// Packet byte buffer with big-endian and LEB128 varlong field reads.
// ----------------------------------------------------------------------------
// Appends: one item per cycle while no read is in progress, no result.
// Reads: the buffer RAM yields one byte per cycle; a read fetches its bytes
//   in S_BYTE, a string adds a length check in S_CHK, and S_DONE loads the
//   result once the output register is free; a failed read ends early.
// Reset clears packet size and read position and sets the string length
//   limit to 32767; buffer contents stay undefined, no clearing pass.
// ----------------------------------------------------------------------------
`include "packet_field_reader_top_macros.svh"

module packet_field_reader_top
    import pfr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_item,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_wdata
);

    t_cmd   cmd;
    t_stat  stat;
    t_state state;

    pfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_cmd   (i_in_item.cmd),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .o_state    (state)
    );

    pfr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    `PFR_ASSERT_NOW(a_fail_zeroed, o_out_valid && o_out_item.status != ST_OK, o_out_item.field_value == '0 && o_out_item.string_offset == '0, "failed read carries data")
    `PFR_ASSERT_NEXT(a_append_no_result, i_in_valid && !o_in_stall && i_in_item.cmd == CMD_APPEND, !$rose(o_out_valid), "append produced a result")
    `PFR_ASSERT_NEXT(a_read_busy, i_in_valid && !o_in_stall && i_in_item.cmd == CMD_READ, o_in_stall, "read did not hold off input")
    `PFR_ASSERT_NOW(a_load_from_done, cmd.load_out, state == S_DONE, "result loaded outside done state")

endmodule

/* rtl/pfr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfr_ctrl
// Sequencer: takes items, steps the byte fetch, runs the string check and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module pfr_ctrl
    import pfr_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  logic   i_in_cmd,
    input  t_stat  i_stat,
    output logic   o_in_stall,
    output t_cmd   o_cmd,
    output t_state o_state
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_in_cmd == CMD_READ) begin
                    n_state = i_stat.kind_bad ? S_DONE : S_BYTE;
                end
            end
            S_BYTE: begin
                if (i_stat.fail) begin
                    n_state = S_DONE;
                end else if (i_stat.last) begin
                    n_state = i_stat.is_string ? S_CHK : S_DONE;
                end
            end
            S_CHK: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall       = (r_state != S_IDLE);
        o_cmd            = '0;
        o_cmd.append     = accept && i_in_cmd == CMD_APPEND;
        o_cmd.start_read = accept && i_in_cmd == CMD_READ;
        o_cmd.byte_step  = (r_state == S_BYTE);
        o_cmd.chk        = (r_state == S_CHK);
        o_cmd.load_out   = (r_state == S_DONE) && i_stat.out_free;
    end

    assign o_state = r_state;

endmodule

/* rtl/pfr_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfr_dp
// Datapath: packet buffer, size and position, byte accumulator, string
// length checks, limit register and output register.
// ----------------------------------------------------------------------------
module pfr_dp
    import pfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_item   i_in_item,
    input  logic       i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_wdata,
    input  t_cmd       i_cmd,
    input  logic       i_out_stall,
    output t_stat      o_stat,
    output logic       o_out_valid,
    output t_out_item  o_out_item
);

    logic [7:0]        r_mem [BUF_DEPTH];
    logic [7:0]        r_rd;
    logic [SIZE_W-1:0] r_size;
    logic [SIZE_W-1:0] r_pos;
    logic [SIZE_W-1:0] r_q;
    logic [SIZE_W-1:0] r_offset;
    logic [VAL_W-1:0]  r_acc;
    logic [CNT_W-1:0]  r_cnt;
    logic [1:0]        r_status;
    logic [2:0]        r_kind;
    logic [LEN_W-1:0]  r_smax;
    logic [LEN_W-1:0]  r_limit;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [SIZE_W-1:0] n_size_base;
    logic [SIZE_W-1:0] n_q_inc;
    logic [SIZE_W-1:0] rd_ptr;
    logic [SIZE_W-1:0] room;
    logic [CNT_W-1:0]  fixed_last;
    logic [5:0]        var_sh;
    logic [VAL_W-1:0]  n_acc;
    logic [VAL_W-1:0]  sext_val;
    logic              is_var;
    logic              overrun;
    logic              overlong;
    logic              len_bad;
    logic              out_acc;

    assign out_acc     = r_out_valid && !i_out_stall;
    assign n_size_base = i_in_item.start_packet ? '0 : r_size;
    assign n_q_inc     = r_q + 1'b1;
    assign rd_ptr      = i_cmd.start_read ? r_pos : (i_cmd.byte_step ? n_q_inc : r_q);

    // packet buffer, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.append && n_size_base < SIZE_W'(BUF_DEPTH)) begin
            r_mem[n_size_base[BUF_AW-1:0]] <= i_in_item.data_byte;
        end
        r_rd <= r_mem[rd_ptr[BUF_AW-1:0]];
    end

    assign is_var   = (r_kind == KIND_VARLONG) || (r_kind == KIND_STRING);
    assign overrun  = (r_q >= r_size);
    assign overlong = r_rd[7] && (r_cnt == VAR_LAST_IDX);
    assign var_sh   = 6'({2'b00, r_cnt} * 6'd7);

    always_comb begin
        case (r_kind)
            KIND_BYTE:  fixed_last = 4'd0;
            KIND_SHORT: fixed_last = 4'd1;
            KIND_INT:   fixed_last = 4'd3;
            default:    fixed_last = 4'd7;
        endcase
    end

    always_comb begin
        if (is_var) begin
            n_acc = r_acc | ({57'b0, r_rd[6:0]} << var_sh);
        end else begin
            n_acc = {r_acc[VAL_W-9:0], r_rd};
        end
    end

    always_comb begin
        case (r_kind)
            KIND_BYTE:  sext_val = {{56{r_acc[7]}}, r_acc[7:0]};
            KIND_SHORT: sext_val = {{48{r_acc[15]}}, r_acc[15:0]};
            KIND_INT:   sext_val = {{32{r_acc[31]}}, r_acc[31:0]};
            default:    sext_val = r_acc;
        endcase
    end

    // string length against limits and bytes left
    assign room    = r_size - r_q;
    assign len_bad = r_acc[VAL_W-1]
                  || (|r_acc[VAL_W-1:LEN_W])
                  || (r_acc[LEN_W-1:0] > r_limit)
                  || ((r_smax != '0) && (r_acc[LEN_W-1:0] > r_smax))
                  || (|r_acc[VAL_W-1:SIZE_W])
                  || (r_acc[SIZE_W-1:0] > room);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= '0;
            r_pos       <= '0;
            r_limit     <= LEN_LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_cmd.append) begin
                if (i_in_item.start_packet) begin
                    r_pos <= '0;
                end
                if (n_size_base < SIZE_W'(BUF_DEPTH)) begin
                    r_size <= n_size_base + 1'b1;
                end else begin
                    r_size <= n_size_base;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
                if (r_status == ST_OK) begin
                    r_pos <= r_q;
                end
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_read) begin
            r_q      <= r_pos;
            r_acc    <= '0;
            r_cnt    <= '0;
            r_offset <= '0;
            r_kind   <= i_in_item.field_kind;
            r_smax   <= i_in_item.string_max;
            r_status <= o_stat.kind_bad ? ST_BAD : ST_OK;
        end
        if (i_cmd.byte_step) begin
            if (overrun) begin
                r_status <= ST_BAD;
            end else if (is_var && overlong) begin
                r_status <= ST_LONG;
            end else begin
                r_acc <= n_acc;
                r_q   <= n_q_inc;
                r_cnt <= r_cnt + 1'b1;
            end
        end
        if (i_cmd.chk) begin
            if (len_bad) begin
                r_status <= ST_BAD;
            end else begin
                r_offset <= r_q;
                r_q      <= r_q + r_acc[SIZE_W-1:0];
            end
        end
        if (i_cmd.load_out) begin
            r_out.status <= r_status;
            if (r_status == ST_OK) begin
                r_out.field_value   <= sext_val;
                r_out.string_offset <= OFF_W'(r_offset);
            end else begin
                r_out.field_value   <= '0;
                r_out.string_offset <= '0;
            end
        end
    end

    always_comb begin
        o_stat           = '0;
        o_stat.kind_bad  = (i_in_item.field_kind > KIND_STRING);
        o_stat.fail      = overrun || (is_var && overlong);
        o_stat.last      = is_var ? !r_rd[7] : (r_cnt == fixed_last);
        o_stat.is_string = (r_kind == KIND_STRING);
        o_stat.out_free  = !r_out_valid || out_acc;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
